### sv/vdn_pkg.sv
package vdn_pkg;

    // sample and accumulator geometry
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int ACC_BITS    = 64;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int PROD_BITS   = 2 * SAMPLE_BITS;
    localparam int MODE_BITS   = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = MODE_BITS;

    // norm modes, codes above MODE_MIN are unsupported
    localparam logic [MODE_BITS-1:0] MODE_TWO = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_ONE = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_MAX = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_MIN = 3'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_NORM_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_PRESENT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_REPEAT  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_REPEAT  = 2'd3;

    localparam logic [ACC_BITS-1:0] SAT_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic [ACC_BITS-1:0] UNSUP_RESULT =
        ACC_BITS'(0) - (ACC_BITS'(1) << FRAC_BITS);
    localparam logic [ACC_BITS-1:0] SQRT_FIRST_BIT = ACC_BITS'(1) << (ACC_BITS - 2);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x_value;
        logic signed [SAMPLE_BITS-1:0] y_value;
        logic                          last_element;
    } vdn_in_t;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] norm_value;
        logic                       saturated;
    } vdn_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul_en;
        logic fold_en;
        logic sqrt_step;
        logic emit_load;
    } vdn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic mode_two;
        logic sqrt_last;
        logic out_busy;
    } vdn_status_t;

endpackage

### sv/vector_difference_norm.sv
// Streaming norm of x - y over one vector, one element pair per request, in
// fixed point (Q8.16 samples, 64-bit saturating sums, Q.16 result). A request
// passes through accept, multiply and fold into the accumulator, and the
// next one is accepted only after its fold. After the last element the
// output register is loaded; in two-norm mode a digit-by-digit square root
// runs before that, one root bit per cycle. The output register lets the
// result wait for out_ready while the next vector starts; a second finished
// result waits until the first has been taken. Configuration writes take
// effect at once and are meant for idle periods only.
module vector_difference_norm (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  vdn_pkg::vdn_in_t                      in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output vdn_pkg::vdn_out_t                     out_data,
    input  logic                                  cfg_we,
    input  logic [vdn_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [vdn_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import vdn_pkg::*;

    vdn_cmd_t    cmd;
    vdn_status_t status;

    // sequencer
    vdn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, configuration and output register
    vdn_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### sv/vdn_ctrl.sv
module vdn_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vdn_pkg::vdn_status_t status,
    output vdn_pkg::vdn_cmd_t    cmd
);
    import vdn_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_FOLD = 5'b00100,
        S_SQRT = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.fold_en = 1'b1;
                if (!status.last)
                begin
                    state_next = S_IDLE;
                end
                else if (status.mode_two)
                begin
                    state_next = S_SQRT;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a request is taken only when no other item is in flight
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_MUL))
        else $error("load did not advance to multiply");

    a_fold_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_en |=> cmd.fold_en)
        else $error("fold did not follow multiply");

    a_emit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && status.out_busy |=> (state_reg == S_EMIT))
        else $error("result left while output register busy");

endmodule

### sv/vdn_datapath.sv
module vdn_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  vdn_pkg::vdn_in_t                      in_data,
    output vdn_pkg::vdn_out_t                     out_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic                                  cfg_we,
    input  logic [vdn_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [vdn_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  vdn_pkg::vdn_cmd_t                     cmd,
    output vdn_pkg::vdn_status_t                  status
);
    import vdn_pkg::*;

    // configuration
    logic [MODE_BITS-1:0] norm_mode_reg;
    logic                 y_present_reg;
    logic                 x_repeat_reg;
    logic                 y_repeat_reg;

    // vector state
    logic [ACC_BITS-1:0]    acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;
    logic                   in_vector_reg;
    logic [SAMPLE_BITS-1:0] first_x_reg;
    logic [SAMPLE_BITS-1:0] first_y_reg;

    // per item pipeline
    logic [SAMPLE_BITS-1:0] mag_reg, mag_next;
    logic [PROD_BITS-1:0]   prod_reg;
    logic                   last_reg;

    // square root
    logic [ACC_BITS-1:0] rem_reg, rem_next;
    logic [ACC_BITS-1:0] root_reg, root_next;
    logic [ACC_BITS-1:0] bit_reg;
    logic [ACC_BITS-1:0] trial;

    // output register
    vdn_out_t out_data_reg;
    logic     out_valid_reg;

    logic [SAMPLE_BITS-1:0] x_eff, y_eff;
    logic [DIFF_BITS-1:0]   diff, diff_neg;
    logic [ACC_BITS-1:0]    addend, sum;
    logic [ACC_BITS-1:0]    result;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_mode_reg <= MODE_TWO;
            y_present_reg <= 1'b1;
            x_repeat_reg  <= 1'b0;
            y_repeat_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NORM_MODE: norm_mode_reg <= cfg_data;
                REG_Y_PRESENT: y_present_reg <= cfg_data[0];
                REG_X_REPEAT:  x_repeat_reg  <= cfg_data[0];
                REG_Y_REPEAT:  y_repeat_reg  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // operand selection and magnitude of the difference
    always_comb
    begin
        x_eff = (x_repeat_reg && in_vector_reg) ? first_x_reg : in_data.x_value;
        y_eff = (y_repeat_reg && in_vector_reg) ? first_y_reg : in_data.y_value;
        if (!y_present_reg)
        begin
            y_eff = '0;
        end
        diff     = {x_eff[SAMPLE_BITS-1], x_eff} - {y_eff[SAMPLE_BITS-1], y_eff};
        diff_neg = DIFF_BITS'(0) - diff;
        mag_next = diff[DIFF_BITS-1] ? diff_neg[SAMPLE_BITS-1:0]
                                     : diff[SAMPLE_BITS-1:0];
    end

    // fold of one magnitude, or of its square in two-norm mode, into the accumulator
    always_comb
    begin
        addend   = (norm_mode_reg == MODE_TWO) ? ACC_BITS'(prod_reg) : ACC_BITS'(mag_reg);
        sum      = acc_reg + addend;
        acc_next = acc_reg;
        ovf_next = ovf_reg;
        case (norm_mode_reg)
            MODE_TWO, MODE_ONE:
            begin
                if (sum[ACC_BITS-1])
                begin
                    acc_next = SAT_MAX;
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = sum;
                end
            end
            MODE_MAX:
            begin
                if (ACC_BITS'(mag_reg) > acc_reg)
                begin
                    acc_next = ACC_BITS'(mag_reg);
                end
            end
            MODE_MIN:
            begin
                if (ACC_BITS'(mag_reg) < acc_reg)
                begin
                    acc_next = ACC_BITS'(mag_reg);
                end
            end
            default: ;
        endcase
    end

    // one digit of the square root
    always_comb
    begin
        trial = root_reg + bit_reg;
        if (rem_reg >= trial)
        begin
            rem_next  = rem_reg - trial;
            root_next = (root_reg >> 1) + bit_reg;
        end
        else
        begin
            rem_next  = rem_reg;
            root_next = root_reg >> 1;
        end
    end

    // result selection
    always_comb
    begin
        case (norm_mode_reg)
            MODE_TWO:                     result = root_reg;
            MODE_ONE, MODE_MAX, MODE_MIN: result = acc_reg;
            default:                      result = UNSUP_RESULT;
        endcase
    end

    // vector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            in_vector_reg <= 1'b0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
        end
        else if (cmd.emit_load)
        begin
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            in_vector_reg <= 1'b0;
        end
        else if (cmd.load && !in_vector_reg)
        begin
            first_x_reg   <= in_data.x_value;
            first_y_reg   <= in_data.y_value;
            acc_reg       <= (norm_mode_reg == MODE_MIN) ? SAT_MAX : '0;
            ovf_reg       <= 1'b0;
            in_vector_reg <= 1'b1;
        end
        else if (cmd.fold_en)
        begin
            acc_reg <= acc_next;
            ovf_reg <= ovf_next;
        end
    end

    // item pipeline and root iteration
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg  <= mag_next;
            last_reg <= in_data.last_element;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_BITS'(mag_reg) * PROD_BITS'(mag_reg);
        end
        if (cmd.fold_en)
        begin
            rem_reg  <= acc_next;
            root_reg <= '0;
            bit_reg  <= SQRT_FIRST_BIT;
        end
        else if (cmd.sqrt_step)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            bit_reg  <= bit_reg >> 2;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_data_reg.norm_value <= result;
            out_data_reg.saturated  <= ovf_reg &&
                ((norm_mode_reg == MODE_TWO) || (norm_mode_reg == MODE_ONE));
        end
    end

    assign out_data         = out_data_reg;
    assign out_valid        = out_valid_reg;
    assign status.last      = last_reg;
    assign status.mode_two  = (norm_mode_reg == MODE_TWO);
    assign status.sqrt_last = bit_reg[0];
    assign status.out_busy  = out_valid_reg && !out_ready;

    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !acc_reg[ACC_BITS-1])
        else $error("accumulator above saturation limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> !(out_valid_reg && !out_ready))
        else $error("pending result overwritten");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |=> out_valid_reg && !in_vector_reg && (acc_reg == '0))
        else $error("emit did not present result and clear vector state");

    a_sat_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.saturated |->
            ((norm_mode_reg == MODE_TWO) || (norm_mode_reg == MODE_ONE)))
        else $error("saturation flag outside summing modes");

endmodule
